// File: rtl/prf_pkg.sv
// Shared types and constants of the pcapng radiotap packet framer.
package prf_pkg;

   typedef enum logic {
      MODE_HEADER  = 1'b0,
      MODE_PAYLOAD = 1'b1
   } mode_type;

   localparam int HDR_BYTES = 44;
   localparam int CNT_W     = 6;
   localparam int TOT_W     = 17;

   localparam logic [31:0] EPB_TYPE      = 32'h0000_0006;
   localparam logic [15:0] BAND_2G       = 16'h0080;
   localparam logic [15:0] BAND_5G       = 16'h0100;
   localparam logic [15:0] FREQ_2G_BASE  = 16'd2407;
   localparam logic [15:0] FREQ_CH14     = 16'd2484;
   localparam logic [15:0] FREQ_5G_BASE  = 16'd5000;
   localparam logic [7:0]  LAST_2G_CHAN  = 8'd13;
   localparam logic [7:0]  CHAN_14       = 8'd14;
   localparam logic [15:0] RT_LEN        = 16'd16;
   localparam logic [31:0] RT_PRESENT    = 32'h0000_002C;
   localparam logic [TOT_W-1:0] RT_BYTES = 17'd16;
   localparam logic [TOT_W-1:0] EPB_OVERHEAD = 17'd32;
   localparam logic [CNT_W-1:0] TRAILER_BYTES = 6'd4;

   localparam int          CSR_ADDR_W      = 3;
   localparam logic        REG_SNAP_LENGTH = 1'b0;
   localparam logic [15:0] SNAP_RESET      = 16'd2048;

   typedef struct packed {
      logic [HDR_BYTES*8-1:0] bytes;
      logic [CNT_W-1:0]       count;
      logic                   ends;
   } job_type;

endpackage

// File: rtl/prf_csr.sv
// APB-style configuration register holding the snap length.
module prf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [prf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output logic [15:0]                     snap_length
);

   logic [15:0] snap_ff;
   logic [15:0] snap_in;
   logic        wr_en;
   logic        sel_snap;

   assign sel_snap   = (csr_paddr[2] == prf_pkg::REG_SNAP_LENGTH);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      snap_in = snap_ff;
      if (wr_en && sel_snap) begin
         snap_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_ff <= prf_pkg::SNAP_RESET;
      end else begin
         snap_ff <= snap_in;
      end
   end

   assign csr_prdata  = sel_snap ? {16'h0000, snap_ff} : 32'h0000_0000;
   assign snap_length = snap_ff;

endmodule

// File: rtl/prf_frame_ctrl.sv
// Frame tracking state and per-word byte job builder.
module prf_frame_ctrl #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  prf_pkg::mode_type      mode,
   input  logic [7:0]             channel,
   input  logic signed [7:0]      signal_strength,
   input  logic [7:0]             rate_mbps,
   input  logic [15:0]            frame_length,
   input  logic [63:0]            timestamp,
   input  logic [7:0]             payload_byte,
   input  logic [15:0]            snap_length,
   output prf_pkg::job_type       job,
   output logic                   job_load
);

   localparam int TW = prf_pkg::TOT_W;

   logic                   in_frame_ff, in_frame_in;
   logic [LENGTH_BITS-1:0] in_left_ff, in_left_in;
   logic [LENGTH_BITS-1:0] kept_left_ff, kept_left_in;
   logic [1:0]             pad_ff, pad_in;
   logic [TW-1:0]          total_ff, total_in;

   logic [LENGTH_BITS-1:0] flen, snap, kept, left_nx;
   logic [TW-1:0]          caplen, total;
   logic [1:0]             pad;
   logic [8:0]             rate2;
   logic [7:0]             rate_b;
   logic [10:0]            ch5;
   logic [15:0]            freq, band;
   logic [prf_pkg::HDR_BYTES*8-1:0] hdr;
   logic [63:0]            trail, seq;
   logic                   has_data, closing;

   assign flen    = frame_length[LENGTH_BITS-1:0];
   assign snap    = snap_length[LENGTH_BITS-1:0];
   assign kept    = (flen < snap) ? flen : snap;
   assign caplen  = prf_pkg::RT_BYTES + {{(TW-LENGTH_BITS){1'b0}}, kept};
   assign pad     = 2'b00 - caplen[1:0];
   assign total   = caplen + {{(TW-2){1'b0}}, pad} + prf_pkg::EPB_OVERHEAD;
   assign rate2   = {rate_mbps, 1'b0};
   assign rate_b  = rate2[8] ? 8'hFF : rate2[7:0];
   assign ch5     = {1'b0, channel, 2'b00} + {3'b000, channel};

   always_comb begin
      if (channel >= 8'd1 && channel <= prf_pkg::LAST_2G_CHAN) begin
         freq = prf_pkg::FREQ_2G_BASE + {5'b0, ch5};
      end else if (channel == prf_pkg::CHAN_14) begin
         freq = prf_pkg::FREQ_CH14;
      end else begin
         freq = prf_pkg::FREQ_5G_BASE + {5'b0, ch5};
      end
   end

   assign band = (channel <= prf_pkg::CHAN_14) ? prf_pkg::BAND_2G : prf_pkg::BAND_5G;

   // little-endian EPB header followed by the radiotap header, byte 0 lowest
   assign hdr = {8'h00, signal_strength, band, freq, 8'h00, rate_b,
                 prf_pkg::RT_PRESENT, prf_pkg::RT_LEN, 8'h00, 8'h00,
                 {{(32-LENGTH_BITS){1'b0}}, flen},
                 {{(32-TW){1'b0}}, caplen},
                 timestamp[31:0], timestamp[63:32], 32'h0000_0000,
                 {{(32-TW){1'b0}}, total}, prf_pkg::EPB_TYPE};

   assign has_data = (kept_left_ff != '0);
   assign left_nx  = in_left_ff - 1'b1;
   assign closing  = (left_nx == '0);
   assign trail    = {{(64-TW){1'b0}}, total_ff} << {pad_ff, 3'b000};
   assign seq      = has_data ? {trail[55:0], payload_byte} : trail;

   always_comb begin
      in_frame_in  = in_frame_ff;
      in_left_in   = in_left_ff;
      kept_left_in = kept_left_ff;
      pad_in       = pad_ff;
      total_in     = total_ff;
      job.bytes    = '0;
      job.count    = '0;
      job.ends     = 1'b0;
      if (accept) begin
         unique case (mode)
            prf_pkg::MODE_HEADER: begin
               in_frame_in = 1'b0;
               if (flen != '0) begin
                  in_frame_in  = 1'b1;
                  in_left_in   = flen;
                  kept_left_in = kept;
                  pad_in       = pad;
                  total_in     = total;
                  job.bytes    = hdr;
                  job.count    = prf_pkg::CNT_W'(prf_pkg::HDR_BYTES);
               end
            end
            prf_pkg::MODE_PAYLOAD: begin
               if (in_frame_ff) begin
                  in_left_in = left_nx;
                  if (has_data) begin
                     kept_left_in = kept_left_ff - 1'b1;
                  end
                  if (closing) begin
                     in_frame_in  = 1'b0;
                     kept_left_in = '0;
                     pad_in       = 2'b00;
                     job.bytes    = {{(prf_pkg::HDR_BYTES*8-64){1'b0}}, seq};
                     job.count    = {{(prf_pkg::CNT_W-1){1'b0}}, has_data}
                                  + {{(prf_pkg::CNT_W-2){1'b0}}, pad_ff}
                                  + prf_pkg::TRAILER_BYTES;
                     job.ends     = 1'b1;
                  end else begin
                     job.bytes = {{(prf_pkg::HDR_BYTES*8-8){1'b0}}, payload_byte};
                     job.count = {{(prf_pkg::CNT_W-1){1'b0}}, has_data};
                  end
               end
            end
            default: begin
               in_frame_in = in_frame_ff;
            end
         endcase
      end
   end

   assign job_load = accept && (job.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         in_left_ff   <= '0;
         kept_left_ff <= '0;
         pad_ff       <= 2'b00;
         total_ff     <= '0;
      end else begin
         in_frame_ff  <= in_frame_in;
         in_left_ff   <= in_left_in;
         kept_left_ff <= kept_left_in;
         pad_ff       <= pad_in;
         total_ff     <= total_in;
      end
   end

endmodule

// File: rtl/prf_byte_emitter.sv
// Byte shift line that drains one job per word into the output register.
module prf_byte_emitter (
   input  logic             clock,
   input  logic             reset,
   input  prf_pkg::job_type job,
   input  logic             job_load,
   input  logic             rsp_tready,
   output logic             req_ready,
   output logic             rsp_tvalid,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

   logic [prf_pkg::HDR_BYTES*8-1:0] bytes_ff, bytes_in;
   logic [prf_pkg::CNT_W-1:0]       remain_ff, remain_in;
   logic                            ends_ff, ends_in;
   logic                            out_valid_ff, out_valid_in;
   logic [7:0]                      out_byte_ff, out_byte_in;
   logic                            out_last_ff, out_last_in;
   logic                            out_adv, emit, on_last;

   assign out_adv   = !out_valid_ff || rsp_tready;
   assign emit      = (remain_ff != '0) && out_adv;
   assign on_last   = (remain_ff == prf_pkg::CNT_W'(1));
   assign req_ready = (remain_ff == '0) || (emit && on_last);

   always_comb begin
      bytes_in     = bytes_ff;
      remain_in    = remain_ff;
      ends_in      = ends_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (job_load) begin
         bytes_in  = job.bytes;
         remain_in = job.count;
         ends_in   = job.ends;
      end else if (emit) begin
         bytes_in  = bytes_ff >> 8;
         remain_in = remain_ff - 1'b1;
      end
      if (out_adv) begin
         out_valid_in = emit;
      end
      if (emit) begin
         out_byte_in = bytes_ff[7:0];
         out_last_in = ends_ff && on_last;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff    <= bytes_in;
      ends_ff     <= ends_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: rtl/pcapng_radiotap_packet_framer.sv
// Top level of the pcapng Enhanced Packet Block framer with radiotap header.
//
// req_ takes words: tuser 0 is a frame header, tuser 1 one payload byte.
// rsp_ delivers the pcapng byte stream, one byte per word; tlast marks the
// final byte of each block trailer. csr_ writes snap_length at address 0.
// rsp_tvalid rises after an accepted word's bytes have passed the shift line
// and the output register. A payload byte that is kept gives one byte; the byte that
// closes a frame gives 4 to 8 bytes (byte if kept, padding, length trailer);
// a header gives 44 bytes. A dropped byte gives nothing.
// The pace is set by the single output byte lane: req_tready is high when
// the byte shift line is empty or is emitting its last byte.
// When rsp_tready is low and the output register holds a valid byte, it keeps it and the shift
// line stops; req_tready stays low while the line holds any byte.
// Reset clears frame state and the shift line, drops any pending output
// and sets snap_length to 2048.
module pcapng_radiotap_packet_framer #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] channel, [15:8] signal_strength, [23:16] rate_mbps,
   // [39:24] frame_length, [103:40] timestamp, [111:104] payload_byte
   input  logic [111:0]                    req_tdata,
   // [0] mode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] out_byte
   output logic [7:0]                      rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [prf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic             accept;
   logic             job_load;
   logic [15:0]      snap_length;
   prf_pkg::job_type job;
   prf_pkg::mode_type mode;

   assign accept = req_tvalid && req_tready;
   assign mode   = prf_pkg::mode_type'(req_tuser);

   prf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .snap_length (snap_length)
   );

   prf_frame_ctrl #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .mode            (mode),
      .channel         (req_tdata[7:0]),
      .signal_strength (req_tdata[15:8]),
      .rate_mbps       (req_tdata[23:16]),
      .frame_length    (req_tdata[39:24]),
      .timestamp       (req_tdata[103:40]),
      .payload_byte    (req_tdata[111:104]),
      .snap_length     (snap_length),
      .job             (job),
      .job_load        (job_load)
   );

   prf_byte_emitter u_emit (
      .clock      (clock),
      .reset      (reset),
      .job        (job),
      .job_load   (job_load),
      .rsp_tready (rsp_tready),
      .req_ready  (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   // total length stays below 2^17, so the top trailer byte is always zero
   a_last_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == 8'h00)
      else $error("block trailer top byte not zero");

   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid right after reset");

   a_snap_write: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]
      |=> snap_length == $past(csr_pwdata[15:0]))
      else $error("snap length write lost");
`endif

endmodule

// File: bench/tb.sv
// Self-checking bench for the pcapng radiotap packet framer: directed and random stream traffic vs. a predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] EPB_BLOCK_TYPE = 32'h0000_0006;
   localparam logic [31:0] RT_FIELDS      = (32'd1 << 2) | (32'd1 << 3) | (32'd1 << 5);
   localparam logic [15:0] RT_HDR_LEN     = 16'd16;
   localparam int          HDR_LEN        = 44;
   localparam int          UNUSED_REG     = 1;
   localparam logic [prf_pkg::CSR_ADDR_W-1:0] SNAP_ADDR   =
      prf_pkg::CSR_ADDR_W'(4 * prf_pkg::REG_SNAP_LENGTH);
   localparam logic [prf_pkg::CSR_ADDR_W-1:0] UNUSED_ADDR =
      prf_pkg::CSR_ADDR_W'(4 * UNUSED_REG);
   localparam int          LONG_HOLD      = 300;

   typedef struct {
      prf_pkg::mode_type mode;
      logic [7:0]        channel;
      logic signed [7:0] signal;
      logic [7:0]        rate;
      logic [15:0]       flen;
      logic [63:0]       ts;
      logic [7:0]        pay;
   } capture_word_type;

   typedef struct packed {
      logic [7:0] value;
      logic       ends;
   } epb_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [111:0]          req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [prf_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   capture_word_type capture_words[$];
   capture_word_type word_on_bus;
   epb_byte_type     epb_due[$];
   epb_byte_type     due;

   // predictor state
   logic [15:0] snap_len = 16'd2048;
   logic        open_frame = 1'b0;
   logic [15:0] bytes_left = '0;
   logic [15:0] kept_left = '0;
   logic [1:0]  pad_left = '0;
   logic [16:0] block_len = '0;

   int mismatches = 0;
   int bytes_seen = 0;
   int send_gap = 0;
   int tx_calm = 0;
   int rx_calm = 0;
   int stall_left = 0;
   int hold_left = 0;
   int hold_asks = 0;
   int holds_granted = 0;

   logic [7:0] chan_picks [8] = '{8'd0, 8'd1, 8'd13, 8'd14, 8'd15, 8'd36, 8'd165, 8'd255};

   pcapng_radiotap_packet_framer #(.LENGTH_BITS(16)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5ns clock = ~clock;

   task automatic flag(input string what);
      mismatches++;
      if (mismatches <= 40) begin
         $display("ERROR %0t: %s", $realtime, what);
      end
   endtask

   function automatic void due_byte(input logic [7:0] value, input logic ends);
      epb_byte_type b;
      b.value = value;
      b.ends  = ends;
      epb_due.push_back(b);
   endfunction

   // expected EPB bytes caused by one accepted word
   task automatic predict_epb(input capture_word_type w);
      logic [31:0] kept, caplen, padded, total, flen32;
      logic [15:0] freq;
      logic [15:0] band;
      logic [7:0]  rate2;
      logic [7:0]  hdr [HDR_LEN];
      logic [31:0] trailer;
      int i;
      if (w.mode == prf_pkg::MODE_HEADER) begin
         open_frame = 1'b0;
         if (w.flen == 16'd0) return;
         flen32 = {16'd0, w.flen};
         kept   = (w.flen < snap_len) ? flen32 : {16'd0, snap_len};
         caplen = 32'd16 + kept;
         padded = (caplen + 32'd3) & ~32'd3;
         total  = padded + 32'd32;
         if (w.channel >= 8'd1 && w.channel <= 8'd13) begin
            freq = 16'd2407 + 16'd5 * {8'd0, w.channel};
         end else if (w.channel == 8'd14) begin
            freq = 16'd2484;
         end else begin
            freq = 16'd5000 + 16'd5 * {8'd0, w.channel};
         end
         band  = (w.channel <= 8'd14) ? 16'h0080 : 16'h0100;
         rate2 = w.rate[7] ? 8'hFF : {w.rate[6:0], 1'b0};
         for (i = 0; i < HDR_LEN; i++) begin
            hdr[i] = 8'h00;
         end
         for (i = 0; i < 4; i++) begin
            hdr[i]      = EPB_BLOCK_TYPE[8*i +: 8];
            hdr[4 + i]  = total[8*i +: 8];
            hdr[12 + i] = w.ts[32 + 8*i +: 8];
            hdr[16 + i] = w.ts[8*i +: 8];
            hdr[20 + i] = caplen[8*i +: 8];
            hdr[24 + i] = flen32[8*i +: 8];
            hdr[32 + i] = RT_FIELDS[8*i +: 8];
         end
         hdr[30] = RT_HDR_LEN[7:0];
         hdr[31] = RT_HDR_LEN[15:8];
         hdr[36] = rate2;
         hdr[38] = freq[7:0];
         hdr[39] = freq[15:8];
         hdr[40] = band[7:0];
         hdr[41] = band[15:8];
         hdr[42] = w.signal;
         for (i = 0; i < HDR_LEN; i++) begin
            due_byte(hdr[i], 1'b0);
         end
         open_frame = 1'b1;
         bytes_left = w.flen;
         kept_left  = kept[15:0];
         pad_left   = padded[1:0] - caplen[1:0];
         block_len  = total[16:0];
      end else if (open_frame) begin
         if (kept_left != 16'd0) begin
            due_byte(w.pay, 1'b0);
            kept_left--;
         end
         bytes_left--;
         if (bytes_left == 16'd0) begin
            for (i = 0; i < pad_left; i++) begin
               due_byte(8'h00, 1'b0);
            end
            trailer = {15'd0, block_len};
            for (i = 0; i < 4; i++) begin
               due_byte(trailer[8*i +: 8], i == 3);
            end
            open_frame = 1'b0;
            kept_left  = '0;
            pad_left   = '0;
         end
      end
   endtask

   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tx_calm > 0) begin
         tx_calm--;
         return 0;
      end
      if (r < 4) begin
         tx_calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_epb(word_on_bus);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0 || capture_words.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_tvalid <= 1'b0;
            end else begin
               word_on_bus = capture_words.pop_front();
               req_tdata  <= {word_on_bus.pay, word_on_bus.ts, word_on_bus.flen,
                              word_on_bus.rate, word_on_bus.signal, word_on_bus.channel};
               req_tuser  <= word_on_bus.mode;
               req_tvalid <= 1'b1;
               send_gap = next_gap();
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_granted != hold_asks) begin
         holds_granted++;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rx_calm > 0) begin
            rx_calm--;
         end else begin
            case ($urandom_range(0, 99)) inside
               [0:2]:   rx_calm = $urandom_range(40, 120);
               [3:22]:  stall_left = $urandom_range(1, 3);
               [23:25]: stall_left = $urandom_range(10, 40);
               default: ;
            endcase
         end
      end
   end

   // output checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (epb_due.size() == 0) begin
            flag($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
         end else begin
            due = epb_due.pop_front();
            if (rsp_tdata !== due.value) begin
               flag($sformatf("byte %0d: out_byte %02h, expected %02h",
                              bytes_seen, rsp_tdata, due.value));
            end
            if (rsp_tlast !== due.ends) begin
               flag($sformatf("byte %0d: block_end %0b, expected %0b",
                              bytes_seen, rsp_tlast, due.ends));
            end
         end
         bytes_seen++;
      end
   end

   task automatic queue_header(input logic [7:0] ch, input logic [7:0] sig,
                               input logic [7:0] rate, input logic [15:0] flen,
                               input logic [63:0] ts);
      capture_word_type w;
      w.mode    = prf_pkg::MODE_HEADER;
      w.channel = ch;
      w.signal  = sig;
      w.rate    = rate;
      w.flen    = flen;
      w.ts      = ts;
      w.pay     = 8'($urandom);
      capture_words.push_back(w);
   endtask

   task automatic queue_payload(input logic [7:0] value);
      capture_word_type w;
      w.mode    = prf_pkg::MODE_PAYLOAD;
      w.channel = 8'($urandom);
      w.signal  = 8'($urandom);
      w.rate    = 8'($urandom);
      w.flen    = 16'($urandom);
      w.ts      = {$urandom, $urandom};
      w.pay     = value;
      capture_words.push_back(w);
   endtask

   // header with random radio fields, then nbytes payload words
   task automatic queue_frame(input logic [15:0] flen, input int nbytes);
      logic [7:0] ch;
      int i;
      ch = ($urandom_range(0, 1) == 0) ? 8'($urandom) : chan_picks[$urandom_range(0, 7)];
      queue_header(ch, 8'($urandom), 8'($urandom), flen, {$urandom, $urandom});
      for (i = 0; i < nbytes; i++) begin
         queue_payload(8'($urandom));
      end
   endtask

   task automatic random_traffic(input int n_items);
      int sent;
      int len;
      int i;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(0, 99)) inside
            [0:77]: begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 20);
               queue_frame(16'(len), len);
               sent += len + 1;
            end
            [78:87]: begin
               len = $urandom_range(0, 4);
               queue_frame(16'($urandom), len);
               sent += len + 1;
            end
            [88:93]: begin
               queue_frame(16'd0, 0);
               sent++;
            end
            default: begin
               for (i = 0; i < $urandom_range(1, 3); i++) begin
                  queue_payload(8'($urandom));
               end
            end
         endcase
      end
      len = $urandom_range(1, 12);
      queue_frame(16'(len), len);
   endtask

   // wait until every word is taken and every byte has come out
   task automatic settle(input int tail);
      while (capture_words.size() != 0 || req_tvalid || epb_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (tail) @(negedge clock);
   endtask

   task automatic csr_write(input logic [prf_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [15:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == SNAP_ADDR) snap_len = value;
   endtask

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [15:0] snaps [7];
      int p;
      snaps = '{16'd3, 16'd65535, 16'd0, 16'd1, 16'd17, 16'd2048,
                16'($urandom_range(1, 300))};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: stray byte, empty frame, channel/rate/signal extremes
      queue_payload(8'hA5);
      queue_header(8'd0, 8'h80, 8'd0, 16'd0, 64'h0123_4567_89AB_CDEF);
      queue_header(8'd1, 8'h80, 8'd0, 16'd1, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_payload(8'hFF);
      queue_header(8'd13, 8'h7F, 8'd127, 16'd2, 64'h0);
      queue_payload(8'h00);
      queue_payload(8'hFF);
      queue_header(8'd14, 8'hC4, 8'd128, 16'd3, {$urandom, $urandom});
      repeat (3) queue_payload(8'($urandom));
      queue_header(8'd15, 8'hD8, 8'd255, 16'd4, {$urandom, $urandom});
      repeat (4) queue_payload(8'($urandom));
      // long frame cut short by a new header
      queue_header(8'd255, 8'h00, 8'd54, 16'hFFFF, {$urandom, $urandom});
      repeat (2) queue_payload(8'($urandom));
      queue_header(8'd36, 8'hB0, 8'd6, 16'd2, {$urandom, $urandom});
      repeat (2) queue_payload(8'($urandom));
      settle(8);

      // snap of one keeps one byte; unused register leaves it alone
      csr_write(SNAP_ADDR, 16'd1);
      csr_write(UNUSED_ADDR, 16'd4);
      queue_frame(16'd3, 3);
      settle(8);

      for (p = 0; p < 7; p++) begin
         csr_write(SNAP_ADDR, snaps[p]);
         if (p == 1) hold_asks++;
         random_traffic(20);
         settle(8);
      end

      settle(20);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
